FILE: rtl/gpat_pkg.sv
// ----------------------------------------------------------------------------
// gpat_pkg
// shared widths, codes and control types of the guarded page access tracker
// ----------------------------------------------------------------------------
package gpat_pkg;

  localparam int ADDR_W  = 48;
  localparam int PN_W    = 36;
  localparam int RIGHT_W = 3;
  localparam int RANGE_W = 4;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int MODE_W  = 2;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 7;

  // input modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAULT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // operations
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_EXEC  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_REPORTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOADED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNMON      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_PERMIT = 3'd4;
  localparam logic [STAT_W-1:0] ST_REPEAT     = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOT_VIOL   = 3'd6;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd7;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_AUTO_RESET  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_PAGE_SHIFT  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_PAGES_TOTAL = 2'd2;

  localparam logic [4:0] SHIFT_MIN = 5'd12;
  localparam logic [4:0] SHIFT_MAX = 5'd16;
  localparam logic [CNT_W-1:0] COMPLETED_MAX = 7'h7f;

  // one table entry as kept in the RAM
  typedef struct packed {
    logic [PN_W-1:0]    pn;
    logic [RIGHT_W-1:0] rights;
    logic [RANGE_W-1:0] rng;
    logic [POS_W-1:0]   pos;
    logic [RIGHT_W-1:0] ops;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept_imm;
    logic fault_start;
    logic scan;
    logic take_hit;
    logic take_miss;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic match;
    logic exhausted;
  } sts_t;

endpackage

FILE: rtl/guarded_page_access_tracker.sv
// ----------------------------------------------------------------------------
// guarded_page_access_tracker
// table of guarded pages, checks access faults against it and reports hits
// ----------------------------------------------------------------------------
// A word is taken at a clock edge with start high and busy low, and its one
// result shows on the out_ ports for exactly one cycle with out_valid high,
// the cycle after the word finishes. The receiver cannot stall, so results
// must be captured when out_valid is seen. Load, clear, non-violation faults
// and faults on an empty table finish in the accepting cycle: busy stays low
// and a new word may follow at once. A violation fault scans the table in
// order, one entry compared per cycle through the single RAM read port,
// with busy high until an entry hits or the table is exhausted. A mode 3
// word is taken and gives no result. Configuration writes (cfg_ready is
// always high) belong in idle time only.
// ----------------------------------------------------------------------------
module guarded_page_access_tracker #(
  parameter int MAX_PAGES = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic [gpat_pkg::MODE_W-1:0]        in_mode,
  input  logic [gpat_pkg::ADDR_W-1:0]        in_address,
  input  logic [gpat_pkg::OP_W-1:0]          in_operation,
  input  logic                               in_is_access_violation,
  input  logic [gpat_pkg::RIGHT_W-1:0]       in_page_rights,
  input  logic [gpat_pkg::RANGE_W-1:0]       in_range_number,
  input  logic [gpat_pkg::POS_W-1:0]         in_index_in_range,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpat_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [gpat_pkg::CFGD_W-1:0]        cfg_data,
  // result side, one-cycle strobe
  output logic                               out_valid,
  output logic [gpat_pkg::STAT_W-1:0]        out_status,
  output logic                               out_restore_request,
  output logic [gpat_pkg::PN_W-1:0]          out_restore_page_number,
  output logic [gpat_pkg::RIGHT_W-1:0]       out_restore_rights,
  output logic [gpat_pkg::RANGE_W-1:0]       out_hit_range,
  output logic [gpat_pkg::POS_W-1:0]         out_hit_page_index,
  output logic [gpat_pkg::CNT_W-1:0]         out_completed_pages,
  output logic [gpat_pkg::CNT_W-1:0]         out_total_pages,
  output logic [gpat_pkg::OP_W-1:0]          out_hit_operation,
  output logic [gpat_pkg::ADDR_W-1:0]        out_hit_address
);

  import gpat_pkg::*;

  cmd_t cmd;   // sequencer commands
  sts_t sts;   // datapath status back to the sequencer

  // configuration registers never stall
  assign cfg_ready = 1'b1;

  // sequencer: idle / scan
  gpat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // table ram, compare, counters and result registers
  gpat_dpath #(
    .MAX_PAGES (MAX_PAGES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_valid               (cfg_valid),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_mode                 (in_mode),
    .in_address              (in_address),
    .in_operation            (in_operation),
    .in_is_access_violation  (in_is_access_violation),
    .in_page_rights          (in_page_rights),
    .in_range_number         (in_range_number),
    .in_index_in_range       (in_index_in_range),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_restore_request     (out_restore_request),
    .out_restore_page_number (out_restore_page_number),
    .out_restore_rights      (out_restore_rights),
    .out_hit_range           (out_hit_range),
    .out_hit_page_index      (out_hit_page_index),
    .out_completed_pages     (out_completed_pages),
    .out_total_pages         (out_total_pages),
    .out_hit_operation       (out_hit_operation),
    .out_hit_address         (out_hit_address)
  );

endmodule

FILE: rtl/gpat_ram.sv
// ----------------------------------------------------------------------------
// gpat_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module gpat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/gpat_ctrl.sv
// ----------------------------------------------------------------------------
// gpat_ctrl
// sequencer: takes words, runs the table scan of a fault
// ----------------------------------------------------------------------------
module gpat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gpat_pkg::sts_t sts,
  output gpat_pkg::cmd_t cmd
);

  import gpat_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r == S_SCAN);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.need_scan) begin
            cmd.fault_start = 1'b1;
            state_nxt       = S_SCAN;
          end else begin
            cmd.accept_imm = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.exhausted) begin
          cmd.take_miss = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/gpat_dpath.sv
// ----------------------------------------------------------------------------
// gpat_dpath
// page table, configuration registers, compare and result registers
// ----------------------------------------------------------------------------
module gpat_dpath #(
  parameter int MAX_PAGES = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gpat_pkg::cmd_t                     cmd,
  output gpat_pkg::sts_t                     sts,
  input  logic                               cfg_valid,
  input  logic [gpat_pkg::CFGI_W-1:0]        cfg_index,
  input  logic [gpat_pkg::CFGD_W-1:0]        cfg_data,
  input  logic [gpat_pkg::MODE_W-1:0]        in_mode,
  input  logic [gpat_pkg::ADDR_W-1:0]        in_address,
  input  logic [gpat_pkg::OP_W-1:0]          in_operation,
  input  logic                               in_is_access_violation,
  input  logic [gpat_pkg::RIGHT_W-1:0]       in_page_rights,
  input  logic [gpat_pkg::RANGE_W-1:0]       in_range_number,
  input  logic [gpat_pkg::POS_W-1:0]         in_index_in_range,
  output logic                               out_valid,
  output logic [gpat_pkg::STAT_W-1:0]        out_status,
  output logic                               out_restore_request,
  output logic [gpat_pkg::PN_W-1:0]          out_restore_page_number,
  output logic [gpat_pkg::RIGHT_W-1:0]       out_restore_rights,
  output logic [gpat_pkg::RANGE_W-1:0]       out_hit_range,
  output logic [gpat_pkg::POS_W-1:0]         out_hit_page_index,
  output logic [gpat_pkg::CNT_W-1:0]         out_completed_pages,
  output logic [gpat_pkg::CNT_W-1:0]         out_total_pages,
  output logic [gpat_pkg::OP_W-1:0]          out_hit_operation,
  output logic [gpat_pkg::ADDR_W-1:0]        out_hit_address
);

  import gpat_pkg::*;

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_PAGES);
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));

  // configuration
  logic              auto_reset_r, auto_reset_nxt;
  logic [4:0]        page_shift_r, page_shift_nxt;
  logic [CNT_W-1:0]  pages_total_r, pages_total_nxt;

  // table bookkeeping
  logic [CW-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]  completed_r, completed_nxt;

  // fault under scan
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PN_W-1:0]   pn_r, pn_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;

  // result registers
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               rreq_r, rreq_nxt;
  logic [PN_W-1:0]    rpn_r, rpn_nxt;
  logic [RIGHT_W-1:0] rrights_r, rrights_nxt;
  logic [RANGE_W-1:0] hrange_r, hrange_nxt;
  logic [POS_W-1:0]   hpos_r, hpos_nxt;
  logic [CNT_W-1:0]   done_r, done_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [OP_W-1:0]    hop_r, hop_nxt;
  logic [ADDR_W-1:0]  haddr_r, haddr_nxt;

  // ram
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  logic [ADDR_W-1:0]  addr_m;
  logic [PN_W-1:0]    in_pn;
  entry_t             ent, new_ent;
  logic               permitted;
  logic [RIGHT_W-1:0] op_bit;

  gpat_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PAGES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign addr_m = in_address & ADDR_MASK;

  // page number with the page shift clamped to its legal span
  always_comb begin
    case (page_shift_r)
      5'd13:   in_pn = PN_W'(addr_m >> 13);
      5'd14:   in_pn = PN_W'(addr_m >> 14);
      5'd15:   in_pn = PN_W'(addr_m >> 15);
      default: begin
        if (page_shift_r >= SHIFT_MAX) begin
          in_pn = PN_W'(addr_m >> SHIFT_MAX);
        end else begin
          in_pn = PN_W'(addr_m >> SHIFT_MIN);
        end
      end
    endcase
  end

  assign ent    = entry_t'(rd_data);
  assign op_bit = RIGHT_W'(3'b001 << op_r);

  always_comb begin
    case (op_r)
      OP_READ:  permitted = ent.rights[0];
      OP_WRITE: permitted = ent.rights[1];
      OP_EXEC:  permitted = ent.rights[2];
      default:  permitted = 1'b0;
    endcase
  end

  always_comb begin
    new_ent     = ent;
    new_ent.ops = ent.ops | op_bit;
  end

  assign sts.need_scan = (in_mode == MODE_FAULT) && in_is_access_violation &&
                         (count_r != '0);
  assign sts.match     = cmp_v_r && (ent.pn == pn_r);
  assign sts.exhausted = !cmp_v_r && (rd_idx_r >= count_r);

  // ram ports: scan reads, load or hit writeback writes
  assign rd_en   = cmd.scan && !sts.match && (rd_idx_r < count_r);
  assign rd_addr = rd_idx_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {in_pn, in_page_rights, in_range_number, in_index_in_range, {RIGHT_W{1'b0}}};
    if (cmd.accept_imm && (in_mode == MODE_LOAD) && (count_r < DEPTH_C)) begin
      wr_en = 1'b1;
    end else if (cmd.take_hit && permitted) begin
      wr_en   = 1'b1;
      wr_addr = cmp_idx_r;
      wr_data = new_ent;
    end
  end

  always_comb begin
    auto_reset_nxt  = auto_reset_r;
    page_shift_nxt  = page_shift_r;
    pages_total_nxt = pages_total_r;
    count_nxt       = count_r;
    completed_nxt   = completed_r;
    addr_nxt        = addr_r;
    pn_nxt          = pn_r;
    op_nxt          = op_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_v_nxt       = cmp_v_r;
    cmp_idx_nxt     = cmp_idx_r;

    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    rreq_nxt      = rreq_r;
    rpn_nxt       = rpn_r;
    rrights_nxt   = rrights_r;
    hrange_nxt    = hrange_r;
    hpos_nxt      = hpos_r;
    done_nxt      = done_r;
    total_nxt     = total_r;
    hop_nxt       = hop_r;
    haddr_nxt     = haddr_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AUTO_RESET:  auto_reset_nxt  = cfg_data[0];
        CFG_PAGE_SHIFT:  page_shift_nxt  = cfg_data[4:0];
        CFG_PAGES_TOTAL: pages_total_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    if (cmd.fault_start) begin
      addr_nxt   = addr_m;
      pn_nxt     = in_pn;
      op_nxt     = in_operation;
      rd_idx_nxt = '0;
      cmp_v_nxt  = 1'b0;
    end

    if (cmd.scan) begin
      cmp_v_nxt   = rd_en;
      cmp_idx_nxt = rd_idx_r[AW-1:0];
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
    end

    // every result shares the clear of the side fields
    if (cmd.accept_imm || cmd.take_hit || cmd.take_miss) begin
      rreq_nxt    = 1'b0;
      rpn_nxt     = '0;
      rrights_nxt = '0;
      hrange_nxt  = '0;
      hpos_nxt    = '0;
      hop_nxt     = '0;
      haddr_nxt   = '0;
      total_nxt   = pages_total_r;
    end

    if (cmd.accept_imm) begin
      out_valid_nxt = 1'b1;
      case (in_mode)
        MODE_LOAD: begin
          if (count_r < DEPTH_C) begin
            count_nxt  = count_r + CW'(1);
            status_nxt = ST_LOADED;
          end else begin
            status_nxt = ST_FULL;
          end
        end
        MODE_CLEAR: begin
          count_nxt  = '0;
          status_nxt = ST_CLEARED;
        end
        MODE_FAULT: begin
          status_nxt = in_is_access_violation ? ST_UNMON : ST_NOT_VIOL;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.take_miss) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_UNMON;
    end

    if (cmd.take_hit) begin
      out_valid_nxt = 1'b1;
      if (!permitted) begin
        status_nxt = ST_NOT_PERMIT;
      end else begin
        if (auto_reset_r) begin
          rreq_nxt    = 1'b1;
          rpn_nxt     = ent.pn;
          rrights_nxt = ent.rights;
        end
        if ((ent.ops != '0) && auto_reset_r) begin
          status_nxt = ST_REPEAT;
        end else begin
          if ((ent.ops == '0) && (completed_r != COMPLETED_MAX)) begin
            completed_nxt = completed_r + CNT_W'(1);
          end
          status_nxt = ST_REPORTED;
          hrange_nxt = ent.rng;
          hpos_nxt   = ent.pos;
          hop_nxt    = op_r;
          haddr_nxt  = addr_r;
        end
      end
    end

    done_nxt = completed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_reset_r  <= 1'b0;
      page_shift_r  <= SHIFT_MIN;
      pages_total_r <= '0;
      count_r       <= '0;
      completed_r   <= '0;
      rd_idx_r      <= '0;
      cmp_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      auto_reset_r  <= auto_reset_nxt;
      page_shift_r  <= page_shift_nxt;
      pages_total_r <= pages_total_nxt;
      count_r       <= count_nxt;
      completed_r   <= completed_nxt;
      rd_idx_r      <= rd_idx_nxt;
      cmp_v_r       <= cmp_v_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    pn_r      <= pn_nxt;
    op_r      <= op_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    rreq_r    <= rreq_nxt;
    rpn_r     <= rpn_nxt;
    rrights_r <= rrights_nxt;
    hrange_r  <= hrange_nxt;
    hpos_r    <= hpos_nxt;
    done_r    <= done_nxt;
    total_r   <= total_nxt;
    hop_r     <= hop_nxt;
    haddr_r   <= haddr_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_restore_request     = rreq_r;
  assign out_restore_page_number = rpn_r;
  assign out_restore_rights      = rrights_r;
  assign out_hit_range           = hrange_r;
  assign out_hit_page_index      = hpos_r;
  assign out_completed_pages     = done_r;
  assign out_total_pages         = total_r;
  assign out_hit_operation       = hop_r;
  assign out_hit_address         = haddr_r;

endmodule
